>>> src/matrix3x3_inverse_defines.svh
// Assertion macros for the matrix inverse RTL.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS

`define M3X3INV_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

`define M3X3INV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`else

`define M3X3INV_ASSERT_NOW(name, ante, cons)
`define M3X3INV_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> src/m3x3inv_pkg.sv
// Widths, index tables and types for the 3x3 matrix inverse pipeline.
package m3x3inv_pkg;

	localparam int IN_WIDTH      = 16;
	localparam int IN_FRAC_BITS  = 12;
	localparam int OUT_WIDTH     = 32;
	localparam int OUT_FRAC_BITS = 16;

	localparam int NUM_ELEM = 9;
	localparam int NUM_PROD = 2 * NUM_ELEM;

	// Cofactor products and the adjugate.
	localparam int PROD_W = 2 * IN_WIDTH;
	localparam int ADJ_W  = PROD_W + 1;
	// Determinant as the first row times the first column of the adjugate.
	localparam int DP_W   = IN_WIDTH + ADJ_W;
	localparam int DET_W  = DP_W + 2;

	// Divider: magnitudes, scaled dividend and quotient bits.
	localparam int NUM_W  = ADJ_W;
	localparam int DEN_W  = DET_W;
	localparam int SH     = IN_FRAC_BITS + OUT_FRAC_BITS + 1;
	localparam int QB     = OUT_WIDTH + 2;
	localparam int DIVD_W = NUM_W + SH;
	localparam int DIV_LAT = QB + 1;

	localparam logic [QB:0] LIM_POS = (QB + 1)'((65'd1 << (OUT_WIDTH - 1)) - 65'd1);
	localparam logic [QB:0] LIM_NEG = (QB + 1)'(65'd1 << (OUT_WIDTH - 1));

	// Adjugate element i is PROD_A/PROD_B product 2i minus product 2i+1.
	// Elements are numbered row-major: 0 = row 1 col 1 ... 8 = row 3 col 3.
	localparam int PROD_A [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2,
		2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PROD_B [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6,
		3, 5, 7, 6, 6, 7, 4, 3};

	typedef struct packed {
		logic neg;
		logic zero;
	} div_ctl_t;

endpackage

>>> src/matrix3x3_inverse.sv
// Streaming 3x3 fixed-point matrix inverse by adjugate and determinant.
//
// Each item on the slave side carries one 3x3 matrix of signed Q4.12 elements; each
// item on the master side carries its inverse as nine signed Q16.16 elements, rounded
// to nearest with ties away from zero and saturated, plus a singular flag (zero
// determinant, all elements zero) and a saturated flag (some element clipped). The
// block is a fixed pipeline that takes one item every cycle while its skid register
// is free. Five stages form the cofactor products, the adjugate, the determinant
// products, the determinant and the magnitudes, then 34 stages of a restoring
// divider produce one quotient bit each for all nine elements in parallel, one
// stage rounds and saturates, and the output register holds the item. The pipeline
// advances as a whole; a second skid register behind the output register absorbs
// the item in flight when the master side stalls, so s_tready drops only in the
// cycle after the stall, from a register.
`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row1_col1, row1_col2, row1_col3, row2_col1 .. row3_col3, 16 bits each from bit 0
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// inv_r1_c1, inv_r1_c2, inv_r1_c3, inv_r2_c1 .. inv_r3_c3, 32 bits each from bit 0
	output logic [287:0] m_tdata,
	// singular (bit 0), saturated (bit 1)
	output logic [1:0]   m_tuser
);
	import m3x3inv_pkg::*;

	logic en;
	logic accept;

	logic skid_v_q;
	logic out_v_q;
	logic [NUM_ELEM*OUT_WIDTH-1:0] out_data_q;
	logic [1:0]                    out_user_q;
	logic [NUM_ELEM*OUT_WIDTH-1:0] skid_data_q;
	logic [1:0]                    skid_user_q;

	// The whole pipeline moves only while the skid register is free.
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// Stage 1: the eighteen cofactor products.
	logic signed [IN_WIDTH-1:0] a_in [NUM_ELEM];
	logic signed [PROD_W-1:0]   p_s1 [NUM_PROD];
	logic signed [IN_WIDTH-1:0] r1_s1 [3];
	logic                       vld_s1;

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_unpack
		assign a_in[i] = s_tdata[i*IN_WIDTH +: IN_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				p_s1[k] <= PROD_W'(a_in[PROD_A[k]]) * PROD_W'(a_in[PROD_B[k]]);
			end
			for (int j = 0; j < 3; j++) begin
				r1_s1[j] <= a_in[j];
			end
		end
	end

	// Stage 2: adjugate elements, row-major in the order of the inverse.
	logic signed [ADJ_W-1:0]    adj_s2 [NUM_ELEM];
	logic signed [IN_WIDTH-1:0] r1_s2 [3];
	logic                       vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				adj_s2[i] <= ADJ_W'(p_s1[2*i]) - ADJ_W'(p_s1[2*i+1]);
			end
			r1_s2 <= r1_s1;
		end
	end

	// Stage 3: first row of the matrix times first column of the adjugate.
	logic signed [DP_W-1:0]  dp_s3 [3];
	logic signed [ADJ_W-1:0] adj_s3 [NUM_ELEM];
	logic                    vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dp_s3[j] <= DP_W'(r1_s2[j]) * DP_W'(adj_s2[3*j]);
			end
			adj_s3 <= adj_s2;
		end
	end

	// Stage 4: the determinant.
	logic signed [DET_W-1:0] det_s4;
	logic signed [ADJ_W-1:0] adj_s4 [NUM_ELEM];
	logic                    vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= DET_W'(dp_s3[0]) + DET_W'(dp_s3[1]) + DET_W'(dp_s3[2]);
			adj_s4 <= adj_s3;
		end
	end

	// Stage 5: magnitudes and result signs for the divider lanes.
	logic [NUM_W-1:0] na_s5 [NUM_ELEM];
	logic [DEN_W-1:0] da_s5;
	div_ctl_t         ctl_s5 [NUM_ELEM];
	logic             sing_s5;
	logic             vld_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				na_s5[i] <= adj_s4[i][ADJ_W-1] ? NUM_W'(-adj_s4[i]) : NUM_W'(adj_s4[i]);
				ctl_s5[i].neg  <= adj_s4[i][ADJ_W-1] ^ det_s4[DET_W-1];
				ctl_s5[i].zero <= det_s4 == '0;
			end
			da_s5   <= det_s4[DET_W-1] ? DEN_W'(-det_s4) : DEN_W'(det_s4);
			sing_s5 <= det_s4 == '0;
		end
	end

	// Divider lanes, one per inverse element.
	logic [OUT_WIDTH-1:0] res_d [NUM_ELEM];
	logic [NUM_ELEM-1:0]  sat_d;

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
		m3x3inv_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (na_s5[i]),
			.den  (da_s5),
			.ctl  (ctl_s5[i]),
			.res  (res_d[i]),
			.sat  (sat_d[i])
		);
	end

	// Valid and singular flags travel beside the divider lanes.
	logic [DIV_LAT-1:0] vld_d_q;
	logic [DIV_LAT-1:0] sing_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_d_q <= '0;
		end else if (en) begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_d_q <= {vld_d_q[DIV_LAT-2:0], vld_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_d_q <= {sing_d_q[DIV_LAT-2:0], sing_s5};
		end
	end

	// Output register and skid register.
	logic [NUM_ELEM*OUT_WIDTH-1:0] pipe_data;
	logic [1:0]                    pipe_user;
	logic                          pipe_v;
	logic                          take;

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_pack
		assign pipe_data[i*OUT_WIDTH +: OUT_WIDTH] = res_d[i];
	end

	assign pipe_user = {|sat_d, sing_d_q[DIV_LAT-1]};
	assign pipe_v    = vld_d_q[DIV_LAT-1] && en;
	assign take      = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= pipe_v;
		end else if (pipe_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (!out_v_q || take) begin
			out_data_q <= pipe_data;
			out_user_q <= pipe_user;
		end else begin
			skid_data_q <= pipe_data;
			skid_user_q <= pipe_user;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`M3X3INV_ASSERT_NOW(a_singular_zero, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])
	`M3X3INV_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q)
	`M3X3INV_ASSERT_NEXT(a_stall_to_skid, out_v_q && !m_tready && pipe_v, skid_v_q)
	`M3X3INV_ASSERT_NEXT(a_frozen_pipe, !en && vld_d_q[DIV_LAT-1], vld_d_q[DIV_LAT-1])

endmodule

>>> src/m3x3inv_div.sv
// Pipelined restoring divider with rounding and saturation for one inverse element.
module m3x3inv_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic [m3x3inv_pkg::NUM_W-1:0]      num,
	input  logic [m3x3inv_pkg::DEN_W-1:0]      den,
	input  m3x3inv_pkg::div_ctl_t              ctl,
	output logic [m3x3inv_pkg::OUT_WIDTH-1:0]  res,
	output logic                               sat
);
	import m3x3inv_pkg::*;

	logic [DIVD_W-1:0] divd;
	logic [DEN_W-1:0]  rem0;
	logic              ovf0;

	logic [DEN_W-1:0] rem_s [QB];
	logic [DEN_W-1:0] den_s [QB];
	logic [QB-1:0]    q_s   [QB];
	logic [QB-1:0]    low_s [QB];
	logic             ovf_s [QB];
	div_ctl_t         ctl_s [QB];

	// The integer part of the scaled dividend must already fall below the divisor.
	assign divd = {num, {SH{1'b0}}};
	assign rem0 = DEN_W'(divd[DIVD_W-1:QB]);
	assign ovf0 = rem0 >= den;

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DEN_W-1:0] in_rem;
		logic [DEN_W-1:0] in_den;
		logic [QB-1:0]    in_q;
		logic [QB-1:0]    in_low;
		logic             in_ovf;
		div_ctl_t         in_ctl;
		logic [DEN_W:0]   r2;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign in_rem = rem0;
			assign in_den = den;
			assign in_q   = '0;
			assign in_low = divd[QB-1:0];
			assign in_ovf = ovf0;
			assign in_ctl = ctl;
		end else begin : g_next
			assign in_rem = rem_s[k-1];
			assign in_den = den_s[k-1];
			assign in_q   = q_s[k-1];
			assign in_low = low_s[k-1];
			assign in_ovf = ovf_s[k-1];
			assign in_ctl = ctl_s[k-1];
		end

		assign r2   = {in_rem, in_low[QB-1]};
		assign diff = r2 - {1'b0, in_den};
		assign ge   = r2 >= {1'b0, in_den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
				den_s[k] <= in_den;
				q_s[k]   <= {in_q[QB-2:0], ge};
				low_s[k] <= {in_low[QB-2:0], 1'b0};
				ovf_s[k] <= in_ovf;
				ctl_s[k] <= in_ctl;
			end
		end
	end

	// The quotient carries one extra bit below the output LSB for rounding.
	logic [QB:0] qr;
	logic [QB:0] lim;
	logic [QB:0] mag;
	logic [QB:0] sres;
	logic        over;

	always_comb begin
		qr   = ({1'b0, q_s[QB-1]} + (QB + 1)'(1)) >> 1;
		lim  = ctl_s[QB-1].neg ? LIM_NEG : LIM_POS;
		over = ovf_s[QB-1] || (qr > lim);
		mag  = over ? lim : qr;
		sres = ctl_s[QB-1].neg ? ((QB + 1)'(0) - mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[QB-1].zero) begin
				res <= '0;
				sat <= 1'b0;
			end else begin
				res <= sres[OUT_WIDTH-1:0];
				sat <= over;
			end
		end
	end

endmodule

>>> test/m3x3inv_checker.sv
// Checker that predicts each matrix inverse and compares it with the block's output.
`timescale 1ns / 100ps

module m3x3inv_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [287:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	import m3x3inv_pkg::*;

	typedef struct packed {
		logic [1:0]   flags;
		logic [287:0] elems;
	} inverse_t;

	inverse_t inverse_q[$];

	// Exact quotient of num * 2^28 / den, rounded half away from zero, saturated.
	function automatic logic [31:0] scaled_quotient(longint num, longint den, ref logic sat);
		logic neg;
		logic [63:0] na, da, q, r, lim;
		logic over;
		neg = (num < 0) != (den < 0);
		na = num < 0 ? -num : num;
		da = den < 0 ? -den : den;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		if (na == 0)
			return 32'd0;
		q = na / da;
		r = na % da;
		over = q > lim;
		for (int i = 0; i < IN_FRAC_BITS + OUT_FRAC_BITS && !over; i++) begin
			if (r >= da - r) begin
				r = r - (da - r);
				q = 2 * q + 1;
			end else begin
				r = r + r;
				q = 2 * q;
			end
			if (q > lim)
				over = 1'b1;
		end
		if (!over && r >= da - r) begin
			q++;
			if (q > lim)
				over = 1'b1;
		end
		if (over) begin
			q = lim;
			sat = 1'b1;
		end
		return neg ? 32'(-q) : 32'(q);
	endfunction

	function automatic inverse_t predict_inverse(logic [143:0] data);
		longint a [9];
		longint adj [9];
		longint det;
		logic sat;
		inverse_t res;
		sat = 1'b0;
		for (int k = 0; k < 9; k++)
			a[k] = longint'($signed(data[16*k +: 16]));
		adj[0] = a[4] * a[8] - a[5] * a[7];
		adj[1] = a[2] * a[7] - a[1] * a[8];
		adj[2] = a[1] * a[5] - a[2] * a[4];
		adj[3] = a[5] * a[6] - a[3] * a[8];
		adj[4] = a[0] * a[8] - a[2] * a[6];
		adj[5] = a[2] * a[3] - a[0] * a[5];
		adj[6] = a[3] * a[7] - a[4] * a[6];
		adj[7] = a[1] * a[6] - a[0] * a[7];
		adj[8] = a[0] * a[4] - a[1] * a[3];
		det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
		res = '0;
		if (det == 0) begin
			res.flags = 2'b01;
			return res;
		end
		for (int k = 0; k < 9; k++)
			res.elems[32*k +: 32] = scaled_quotient(adj[k], det, sat);
		res.flags = {sat, 1'b0};
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		inverse_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				inverse_q.push_back(predict_inverse(s_tdata));
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("Unexpected result %h flags %b", m_tdata, m_tuser);
				end else begin
					want = inverse_q.pop_front();
					if (want.elems !== m_tdata || want.flags !== m_tuser) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("Mismatch: expected %h flags %b, got %h flags %b",
								want.elems, want.flags, m_tdata, m_tuser);
					end
				end
			end
			pending <= inverse_q.size();
		end
	end
endmodule

>>> test/tb.sv
// Testbench top: drives matrices into the inverse pipeline and reports the verdict.
`timescale 1ns / 100ps

module tb;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [287:0] m_tdata;
	logic [1:0]   m_tuser;
	int           fail_count;
	int           pending;
	logic         hold_off;
	logic         hold_req;
	logic         stim_done;
	logic [143:0] matrix_q[$];

	matrix3x3_inverse dut (.*);

	m3x3inv_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Element values that stress the sign, the range ends and small magnitudes.
	function automatic logic [15:0] pick_elem();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h1000;
			4: return 16'(int'($urandom_range(0, 6)) - 3);
			5: return 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [143:0] random_matrix();
		logic [143:0] m;
		for (int k = 0; k < 9; k++)
			m[16*k +: 16] = pick_elem();
		// Sometimes copy one row onto another to force a zero determinant.
		if ($urandom_range(0, 9) == 0)
			m[95:48] = m[47:0];
		return m;
	endfunction

	// Receiver stalls on a random pattern, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		logic [143:0] m;
		logic [143:0] identity;
		int gap;
		int burst;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 1'b0;
		stim_done = 1'b0;
		identity = '0;
		identity[15:0] = 16'h1000;
		identity[79:64] = 16'h1000;
		identity[143:128] = 16'h1000;
		// Directed matrices: identity, zero, extremes, tiny determinant, sign mix.
		matrix_q.push_back(identity);
		matrix_q.push_back('0);
		matrix_q.push_back({9{16'h7fff}});
		matrix_q.push_back({9{16'h8000}});
		m = '0;
		m[15:0] = 16'h8000; m[79:64] = 16'h8000; m[143:128] = 16'h8000;
		matrix_q.push_back(m);
		m = '0;
		m[15:0] = 16'h7fff; m[79:64] = 16'h8000; m[143:128] = 16'h7fff;
		matrix_q.push_back(m);
		m = '0;
		m[15:0] = 16'h0001; m[79:64] = 16'h0001; m[143:128] = 16'h0001;
		matrix_q.push_back(m);
		m = identity;
		m[31:16] = 16'hffff; m[127:112] = 16'h7fff;
		matrix_q.push_back(m);
		m = '0;
		m[47:32] = 16'h1000; m[79:64] = 16'h1000; m[111:96] = 16'h1000;
		matrix_q.push_back(m);
		matrix_q.push_back({16'h0003, 16'h0002, 16'h0001, 16'h0002, 16'h0005,
			16'h0004, 16'h0001, 16'h0004, 16'h0003});
		matrix_q.push_back({9{16'haaaa}});
		matrix_q.push_back({9{16'h5555}});
		for (int k = 0; k < 950; k++)
			matrix_q.push_back(random_matrix());
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int n = 0; matrix_q.size() > 0; n++) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && matrix_q.size() > 0; b++) begin
				s_tdata <= matrix_q.pop_front();
				s_tvalid <= 1'b1;
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				@(negedge clk);
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (n == 10 && gap == 0)
				gap = 1;
			// With no gap the next burst keeps tvalid high.
			if (gap != 0)
				s_tvalid <= 1'b0;
			if (n == 5)
				hold_req <= 1'b1;
			if (n == 10) begin
				// Drain everything before going on.
				while (pending != 0)
					@(negedge clk);
			end
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Long receiver hold-off, counted here while the sender keeps offering items.
	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		hold_off <= 1'b1;
		repeat (150) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		wait (stim_done);
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/m3x3inv_pkg.sv
src/m3x3inv_div.sv
src/matrix3x3_inverse.sv
test/m3x3inv_checker.sv
test/tb.sv
